/* rtl/cats_pkg.sv */
// Shared types and constants of the cache tag directory.
package cats_pkg;

	localparam int HITS_W    = 16;
	localparam int LINE_O_W  = 3;
	localparam int ETAG_W    = 6;
	localparam int WAYS_W    = 2;

	typedef logic [HITS_W-1:0] hits_t;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_HIT,
		UPD_FILL
	} upd_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_BASE,
		ST_LAUNCH,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	// search record flags carried from cell to cell
	typedef struct packed {
		logic hit;
		logic seen;
		logic vvalid;
	} srch_flags_t;

endpackage

/* rtl/cats_if.sv */
// Handshake channels: request address, response, associativity write.
interface cats_req_if #(parameter int AW = 8);
	logic          valid;
	logic          ready;
	logic [AW-1:0] address;
	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface cats_rsp_if;
	import cats_pkg::*;
	logic                valid;
	logic                ready;
	logic                hit;
	logic                replaced;
	logic [LINE_O_W-1:0] line_index;
	logic [ETAG_W-1:0]   evicted_tag;
	modport source (output valid, output hit, output replaced, output line_index,
		output evicted_tag, input ready);
	modport sink   (input valid, input hit, input replaced, input line_index,
		input evicted_tag, output ready);
endinterface

interface cats_cfg_if;
	import cats_pkg::*;
	logic              valid;
	logic              ready;
	logic [WAYS_W-1:0] ways_log2;
	modport source (output valid, output ways_log2, input ready);
	modport sink   (input valid, input ways_log2, output ready);
endinterface

/* rtl/cats_cell.sv */
// One cache line: tag, valid, hit count, plus one step of the set search.
module cats_cell #(
	parameter int LINES = 8,
	parameter int TAG_W = 6,
	parameter int IDX   = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  cats_pkg::upd_op_t          upd_op,
	input  logic [$clog2(LINES)-1:0]   upd_line,
	input  logic [TAG_W-1:0]           upd_tag,
	input  logic [$clog2(LINES+1)-1:0] base,
	input  logic [$clog2(LINES+1)-1:0] lim,
	input  logic [TAG_W-1:0]           tag,
	input  logic                       tok_in,
	input  cats_pkg::srch_flags_t      fl_in,
	input  logic [$clog2(LINES)-1:0]   line_in,
	input  logic [$clog2(LINES)-1:0]   vidx_in,
	input  cats_pkg::hits_t            vhits_in,
	input  logic [TAG_W-1:0]           vtag_in,
	output logic                       tok_out,
	output cats_pkg::srch_flags_t      fl_out,
	output logic [$clog2(LINES)-1:0]   line_out,
	output logic [$clog2(LINES)-1:0]   vidx_out,
	output cats_pkg::hits_t            vhits_out,
	output logic [TAG_W-1:0]           vtag_out
);
	import cats_pkg::*;

	localparam int IDX_W = $clog2(LINES);
	localparam int CNT_W = $clog2(LINES+1);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

	logic             valid_q;
	hits_t            hits_q;
	logic [TAG_W-1:0] tag_q;

	logic             tok_q;
	srch_flags_t      fl_q;
	logic [IDX_W-1:0] line_q;
	logic [IDX_W-1:0] vidx_q;
	hits_t            vhits_q;
	logic [TAG_W-1:0] vtag_q;

	logic             in_set;
	logic             mine;
	srch_flags_t      fl_n;
	logic [IDX_W-1:0] line_n;
	logic [IDX_W-1:0] vidx_n;
	hits_t            vhits_n;
	logic [TAG_W-1:0] vtag_n;

	assign in_set = (MY_POS >= base) && (MY_POS < lim);
	assign mine   = (upd_line == MY_IDX);

	always_comb begin
		fl_n    = fl_in;
		line_n  = line_in;
		vidx_n  = vidx_in;
		vhits_n = vhits_in;
		vtag_n  = vtag_in;
		if (in_set) begin
			if (!fl_in.hit && valid_q && (tag_q == tag)) begin
				fl_n.hit = 1'b1;
				line_n   = MY_IDX;
			end
			// strict less-than keeps the lowest index on ties
			if (!fl_in.seen || (hits_q < vhits_in)) begin
				fl_n.seen   = 1'b1;
				fl_n.vvalid = valid_q;
				vidx_n      = MY_IDX;
				vhits_n     = hits_q;
				vtag_n      = tag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hits_q  <= '0;
		end else if (clr) begin
			valid_q <= 1'b0;
			hits_q  <= '0;
		end else if (mine) begin
			case (upd_op)
				UPD_HIT: begin
					if (hits_q != '1)
						hits_q <= hits_q + hits_t'(1);
				end
				UPD_FILL: begin
					valid_q <= 1'b1;
					hits_q  <= hits_t'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mine && (upd_op == UPD_FILL))
			tag_q <= upd_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_q <= 1'b0;
		else
			tok_q <= tok_in;
	end

	always_ff @(posedge clk) begin
		if (tok_in) begin
			fl_q    <= fl_n;
			line_q  <= line_n;
			vidx_q  <= vidx_n;
			vhits_q <= vhits_n;
			vtag_q  <= vtag_n;
		end
	end

	assign tok_out   = tok_q;
	assign fl_out    = fl_q;
	assign line_out  = line_q;
	assign vidx_out  = vidx_q;
	assign vhits_out = vhits_q;
	assign vtag_out  = vtag_q;

endmodule

/* rtl/cats_div.sv */
// Restoring divider: splits the block number into set index and tag.
module cats_div #(
	parameter int LINES = 8,
	parameter int BLK_W = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [BLK_W-1:0]           blk,
	input  logic [$clog2(LINES+1)-1:0] sets,
	output logic                       done,
	output logic [BLK_W-1:0]           quo,
	output logic [$clog2(LINES+1)-1:0] rem
);
	localparam int CNT_W  = $clog2(LINES+1);
	localparam int DCNT_W = $clog2(BLK_W+1);

	logic [BLK_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[BLK_W-1]};
	assign ge    = (trial >= {1'b0, sets});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dcnt_q <= '0;
		else if (start)
			dcnt_q <= DCNT_W'(BLK_W);
		else if (dcnt_q != '0)
			dcnt_q <= dcnt_q - DCNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= blk;
			rem_q <= '0;
		end else if (dcnt_q != '0) begin
			quo_q <= BLK_W'({quo_q, ge});
			rem_q <= ge ? CNT_W'(trial - {1'b0, sets}) : CNT_W'(trial);
		end
	end

	// high in the cycle of the last step
	assign done = (dcnt_q == DCNT_W'(1));
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/configurable_assoc_cache_tag_store_unit.sv */
// Steps: accept, BLK_W divider steps, base setup, launch, LINES cell hops, update.
// The update state waits while the response register is still held by the sink.
// A new request is taken only in idle, once the last one has left the update state.
// The divider is bit-serial; the search record walks the row one cell per cycle.
// Reset (arst_n low) and any associativity change clear all lines at once.
// BLK_W = ADDRESS_BITS - OFFSET_BITS, or 1 if that is not positive.
module configurable_assoc_cache_tag_store_unit #(
	parameter int LINES        = 8,
	parameter int ADDRESS_BITS = 8,
	parameter int OFFSET_BITS  = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	cats_cfg_if.sink   cfg,
	cats_req_if.sink   req,
	cats_rsp_if.source rsp
);
	import cats_pkg::*;

	localparam int IDX_W = $clog2(LINES);
	localparam int CNT_W = $clog2(LINES+1);
	localparam int BLK_W = (ADDRESS_BITS > OFFSET_BITS) ? ADDRESS_BITS - OFFSET_BITS : 1;
	localparam int WAYS1 = (2 > LINES) ? LINES : 2;
	localparam int WAYS2 = (4 > LINES) ? LINES : 4;
	localparam int WAYS3 = (8 > LINES) ? LINES : 8;
	localparam int SETS0 = LINES;
	localparam int SETS1 = LINES / WAYS1;
	localparam int SETS2 = LINES / WAYS2;
	localparam int SETS3 = LINES / WAYS3;
	localparam logic [1:0] W_DM = 2'd0;
	localparam logic [1:0] W_2  = 2'd1;
	localparam logic [1:0] W_4  = 2'd2;

	state_t            state_q, state_n;
	logic [WAYS_W-1:0] ways_q;
	logic              clr;

	logic [CNT_W-1:0]  wcnt, sets;
	logic [ADDRESS_BITS+BLK_W-1:0] addr_ext;
	logic [BLK_W-1:0]  blk;
	logic              div_start, div_done;
	logic [BLK_W-1:0]  quo;
	logic [CNT_W-1:0]  rem;
	logic [CNT_W-1:0]  base_q, lim_q;

	logic              launch;
	logic              out_free;
	upd_op_t           upd_op;
	logic [IDX_W-1:0]  upd_line;

	logic [LINES-1:0]  tok;
	srch_flags_t       fl    [LINES];
	logic [IDX_W-1:0]  line  [LINES];
	logic [IDX_W-1:0]  vidx  [LINES];
	hits_t             vhits [LINES];
	logic [BLK_W-1:0]  vtag  [LINES];

	srch_flags_t       fl_fin;
	logic              rsp_valid_q;
	logic              hit_q, repl_q;
	logic [LINE_O_W-1:0] line_q;
	logic [ETAG_W-1:0] etag_q;

	// configuration
	assign clr = cfg.valid && cfg.ready && (cfg.ways_log2 != ways_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ways_q <= '0;
		else if (cfg.valid && cfg.ready)
			ways_q <= cfg.ways_log2;
	end

	always_comb begin
		case (ways_q)
			W_DM: begin
				wcnt = CNT_W'(1);
				sets = CNT_W'(SETS0);
			end
			W_2: begin
				wcnt = CNT_W'(WAYS1);
				sets = CNT_W'(SETS1);
			end
			W_4: begin
				wcnt = CNT_W'(WAYS2);
				sets = CNT_W'(SETS2);
			end
			default: begin
				wcnt = CNT_W'(WAYS3);
				sets = CNT_W'(SETS3);
			end
		endcase
	end

	// address split
	assign addr_ext = {{BLK_W{1'b0}}, req.address};
	assign blk      = BLK_W'(addr_ext >> OFFSET_BITS);

	cats_div #(
		.LINES (LINES),
		.BLK_W (BLK_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.blk    (blk),
		.sets   (sets),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_BASE) begin
			base_q <= CNT_W'(rem * wcnt);
			lim_q  <= CNT_W'(rem * wcnt) + wcnt;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (req.valid) state_n = ST_DIV;
			ST_DIV:    if (div_done) state_n = ST_BASE;
			ST_BASE:   state_n = ST_LAUNCH;
			ST_LAUNCH: state_n = ST_SEARCH;
			ST_SEARCH: if (tok[LINES-1]) state_n = ST_UPDATE;
			ST_UPDATE: if (out_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	assign fl_fin = fl[LINES-1];

	always_comb begin
		req.ready = 1'b0;
		cfg.ready = 1'b1;
		div_start = 1'b0;
		launch    = 1'b0;
		upd_op    = UPD_NONE;
		upd_line  = fl_fin.hit ? line[LINES-1] : vidx[LINES-1];
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				div_start = req.valid;
			end
			ST_LAUNCH: launch = 1'b1;
			ST_UPDATE: begin
				if (out_free)
					upd_op = fl_fin.hit ? UPD_HIT : UPD_FILL;
			end
			default: ;
		endcase
	end

	// row of line cells; the search record enters at cell 0
	for (genvar i = 0; i < LINES; i++) begin : g_cell
		logic             tok_i;
		srch_flags_t      fl_i;
		logic [IDX_W-1:0] line_i, vidx_i;
		hits_t            vhits_i;
		logic [BLK_W-1:0] vtag_i;

		if (i == 0) begin : g_head
			assign tok_i   = launch;
			assign fl_i    = '0;
			assign line_i  = '0;
			assign vidx_i  = '0;
			assign vhits_i = '0;
			assign vtag_i  = '0;
		end else begin : g_link
			assign tok_i   = tok[i-1];
			assign fl_i    = fl[i-1];
			assign line_i  = line[i-1];
			assign vidx_i  = vidx[i-1];
			assign vhits_i = vhits[i-1];
			assign vtag_i  = vtag[i-1];
		end

		cats_cell #(
			.LINES (LINES),
			.TAG_W (BLK_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clr       (clr),
			.upd_op    (upd_op),
			.upd_line  (upd_line),
			.upd_tag   (quo),
			.base      (base_q),
			.lim       (lim_q),
			.tag       (quo),
			.tok_in    (tok_i),
			.fl_in     (fl_i),
			.line_in   (line_i),
			.vidx_in   (vidx_i),
			.vhits_in  (vhits_i),
			.vtag_in   (vtag_i),
			.tok_out   (tok[i]),
			.fl_out    (fl[i]),
			.line_out  (line[i]),
			.vidx_out  (vidx[i]),
			.vhits_out (vhits[i]),
			.vtag_out  (vtag[i])
		);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if ((state_q == ST_UPDATE) && out_free)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_UPDATE) && out_free) begin
			hit_q  <= fl_fin.hit;
			repl_q <= !fl_fin.hit && fl_fin.vvalid;
			line_q <= LINE_O_W'(upd_line);
			etag_q <= (!fl_fin.hit && fl_fin.vvalid) ? ETAG_W'(vtag[LINES-1]) : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.replaced    = repl_q;
	assign rsp.line_index  = line_q;
	assign rsp.evicted_tag = etag_q;

	// checks
	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one search record in the cell row");

	a_tok_state: assert property (@(posedge clk) disable iff (!arst_n)
		(tok != '0) |-> (state_q == ST_SEARCH))
		else $error("search record moving outside the search phase");

	a_upd_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_op != UPD_NONE) |-> (CNT_W'(upd_line) >= base_q && CNT_W'(upd_line) < lim_q))
		else $error("update targets a line outside the selected set");

	a_rsp_set: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_UPDATE) && out_free) |=> (rsp.valid && !(rsp.hit && rsp.replaced)))
		else $error("response missing or both hit and replaced");

endmodule
